/* hdl/qvr_pkg.sv */
// Package for the quaternion vector rotation block.
// Holds default widths and configuration register indexes; depends on nothing.
package qvr_pkg;

  localparam int VEC_WIDTH_DEF  = 24;
  localparam int QUAT_WIDTH_DEF = 16;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_QUAT_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_SCALAR = 2'd3;

endpackage

/* hdl/quaternion_vector_rotate.sv */
// Quaternion vector rotation, four register stages: capture, coefficient times vector,
// row sum with rounding, saturation. One transaction per cycle when the output is not
// stalled; a result is held in the output register while stalled.
// The coefficient matrix is rebuilt from the quaternion registers in two stages.
// Reset clears all valid bits and loads the identity quaternion and matrix.
module quaternion_vector_rotate #(
  parameter int VEC_WIDTH  = qvr_pkg::VEC_WIDTH_DEF,
  parameter int QUAT_WIDTH = qvr_pkg::QUAT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [qvr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [QUAT_WIDTH-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VEC_WIDTH-1:0]   vec_x_i,
  input  logic signed [VEC_WIDTH-1:0]   vec_y_i,
  input  logic signed [VEC_WIDTH-1:0]   vec_z_i,
  input  logic signed [VEC_WIDTH-1:0]   vec_w_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [VEC_WIDTH-1:0]   rot_x_o,
  output logic signed [VEC_WIDTH-1:0]   rot_y_o,
  output logic signed [VEC_WIDTH-1:0]   rot_z_o,
  output logic signed [VEC_WIDTH-1:0]   out_w_o
);

  localparam int F   = QUAT_WIDTH - 1;
  localparam int PW  = 2 * QUAT_WIDTH;
  localparam int CPW = 2 * QUAT_WIDTH + 3;
  localparam int CW  = CPW - F;
  localparam int MW  = CW + VEC_WIDTH;
  localparam int AW  = MW + 2;
  localparam int SW  = AW - F;

  localparam int P_II = 0;
  localparam int P_JJ = 1;
  localparam int P_KK = 2;
  localparam int P_UI = 3;
  localparam int P_UJ = 4;
  localparam int P_UK = 5;
  localparam int P_IJ = 6;
  localparam int P_IK = 7;
  localparam int P_JK = 8;

  localparam logic signed [CPW-1:0] C_ONE  = {{(CPW-2*F-1){1'b0}}, 1'b1, {(2*F){1'b0}}};
  localparam logic signed [CPW-1:0] C_HALF = {{(CPW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [CW-1:0]  COEF_ONE = {{(CW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [AW-1:0]  A_HALF = {{(AW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [SW-1:0]  SAT_HI = {{(SW-VEC_WIDTH+1){1'b0}}, {(VEC_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0]  SAT_LO = {{(SW-VEC_WIDTH+1){1'b1}}, {(VEC_WIDTH-1){1'b0}}};
  localparam logic [QUAT_WIDTH-1:0] SCALAR_RST = {1'b0, {(QUAT_WIDTH-1){1'b1}}};

  function automatic logic signed [CW-1:0] mk_coef(input logic base,
                                                   input logic signed [CPW-1:0] twice_sum);
    logic signed [CPW-1:0] pre;
    pre = (base ? C_ONE : '0) + twice_sum + C_HALF;
    return $signed(pre[CPW-1:F]);
  endfunction

  // Configuration registers.
  logic signed [QUAT_WIDTH-1:0] qi_q, qj_q, qk_q, qu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qi_q <= '0;
      qj_q <= '0;
      qk_q <= '0;
      qu_q <= $signed(SCALAR_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qvr_pkg::REG_QUAT_X:      qi_q <= $signed(cfg_data_i);
        qvr_pkg::REG_QUAT_Y:      qj_q <= $signed(cfg_data_i);
        qvr_pkg::REG_QUAT_Z:      qk_q <= $signed(cfg_data_i);
        qvr_pkg::REG_QUAT_SCALAR: qu_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Pairwise products and rotation coefficients.
  logic signed [PW-1:0] pp_d [9];
  logic signed [PW-1:0] pp_q [9];
  logic signed [CW-1:0] coef_d [9];
  logic signed [CW-1:0] coef_q [9];

  always_comb begin
    pp_d[P_II] = PW'(qi_q) * PW'(qi_q);
    pp_d[P_JJ] = PW'(qj_q) * PW'(qj_q);
    pp_d[P_KK] = PW'(qk_q) * PW'(qk_q);
    pp_d[P_UI] = PW'(qu_q) * PW'(qi_q);
    pp_d[P_UJ] = PW'(qu_q) * PW'(qj_q);
    pp_d[P_UK] = PW'(qu_q) * PW'(qk_q);
    pp_d[P_IJ] = PW'(qi_q) * PW'(qj_q);
    pp_d[P_IK] = PW'(qi_q) * PW'(qk_q);
    pp_d[P_JK] = PW'(qj_q) * PW'(qk_q);
  end

  always_comb begin
    coef_d[0] = mk_coef(1'b1, -((CPW'(pp_q[P_JJ]) + CPW'(pp_q[P_KK])) <<< 1));
    coef_d[1] = mk_coef(1'b0, (CPW'(pp_q[P_IJ]) - CPW'(pp_q[P_UK])) <<< 1);
    coef_d[2] = mk_coef(1'b0, (CPW'(pp_q[P_IK]) + CPW'(pp_q[P_UJ])) <<< 1);
    coef_d[3] = mk_coef(1'b0, (CPW'(pp_q[P_IJ]) + CPW'(pp_q[P_UK])) <<< 1);
    coef_d[4] = mk_coef(1'b1, -((CPW'(pp_q[P_II]) + CPW'(pp_q[P_KK])) <<< 1));
    coef_d[5] = mk_coef(1'b0, (CPW'(pp_q[P_JK]) - CPW'(pp_q[P_UI])) <<< 1);
    coef_d[6] = mk_coef(1'b0, (CPW'(pp_q[P_IK]) - CPW'(pp_q[P_UJ])) <<< 1);
    coef_d[7] = mk_coef(1'b0, (CPW'(pp_q[P_JK]) + CPW'(pp_q[P_UI])) <<< 1);
    coef_d[8] = mk_coef(1'b1, -((CPW'(pp_q[P_II]) + CPW'(pp_q[P_JJ])) <<< 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < 9; n++) begin
        pp_q[n]   <= '0;
        coef_q[n] <= (n % 4 == 0) ? COEF_ONE : '0;
      end
    end else begin
      for (int n = 0; n < 9; n++) begin
        pp_q[n]   <= pp_d[n];
        coef_q[n] <= coef_d[n];
      end
    end
  end

  // Pipeline control.
  logic v1_q, v2_q, v3_q, v4_q;
  logic v1_d, v2_d, v3_d, v4_d;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign v1_d = rdy1 ? in_valid_i : v1_q;
  assign v2_d = rdy2 ? v1_q : v2_q;
  assign v3_d = rdy3 ? v2_q : v3_q;
  assign v4_d = rdy4 ? v3_q : v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  // Datapath.
  logic signed [VEC_WIDTH-1:0] vec_d [3];
  logic signed [VEC_WIDTH-1:0] vec_q [3];
  logic signed [MW-1:0]        mul_d [9];
  logic signed [MW-1:0]        mul_q [9];
  logic signed [AW-1:0]        acc_d [3];
  logic signed [AW-1:0]        acc_q [3];
  logic signed [SW-1:0]        sh    [3];
  logic signed [VEC_WIDTH-1:0] rot_d [3];
  logic signed [VEC_WIDTH-1:0] rot_q [3];
  logic signed [VEC_WIDTH-1:0] w1_q, w2_q, w3_q, w4_q;

  always_comb begin
    vec_d[0] = vec_x_i;
    vec_d[1] = vec_y_i;
    vec_d[2] = vec_z_i;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mul_d[r*3+c] = MW'(coef_q[r*3+c]) * MW'(vec_q[c]);
      end
      acc_d[r] = AW'(mul_q[r*3]) + AW'(mul_q[r*3+1]) + AW'(mul_q[r*3+2]) + A_HALF;
      sh[r] = $signed(acc_q[r][AW-1:F]);
      if (sh[r] > SAT_HI) begin
        rot_d[r] = SAT_HI[VEC_WIDTH-1:0];
      end else if (sh[r] < SAT_LO) begin
        rot_d[r] = SAT_LO[VEC_WIDTH-1:0];
      end else begin
        rot_d[r] = sh[r][VEC_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      vec_q <= vec_d;
      w1_q  <= vec_w_i;
    end
    if (rdy2) begin
      mul_q <= mul_d;
      w2_q  <= w1_q;
    end
    if (rdy3) begin
      acc_q <= acc_d;
      w3_q  <= w2_q;
    end
    if (rdy4) begin
      rot_q <= rot_d;
      w4_q  <= w3_q;
    end
  end

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v4_q;
  assign rot_x_o     = rot_q[0];
  assign rot_y_o     = rot_q[1];
  assign rot_z_o     = rot_q[2];
  assign out_w_o     = w4_q;

endmodule

/* hdl/qvr_checker.sv */
// Port-level checker for the quaternion vector rotation block, bound to quaternion_vector_rotate.
// Depends on qvr_pkg for default widths.
module qvr_checker #(
  parameter int VEC_WIDTH  = qvr_pkg::VEC_WIDTH_DEF,
  parameter int QUAT_WIDTH = qvr_pkg::QUAT_WIDTH_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [qvr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic [QUAT_WIDTH-1:0]         cfg_data_i,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic signed [VEC_WIDTH-1:0]   vec_x_i,
  input logic signed [VEC_WIDTH-1:0]   vec_y_i,
  input logic signed [VEC_WIDTH-1:0]   vec_z_i,
  input logic signed [VEC_WIDTH-1:0]   vec_w_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [VEC_WIDTH-1:0]   rot_x_o,
  input logic signed [VEC_WIDTH-1:0]   rot_y_o,
  input logic signed [VEC_WIDTH-1:0]   rot_z_o,
  input logic signed [VEC_WIDTH-1:0]   out_w_o
);

  logic cfg_seen_q;
  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_seen_q <= 1'b0;
    end else if (cfg_we_i) begin
      cfg_seen_q <= 1'b1;
    end
  end

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(rot_x_o) && $stable(rot_y_o)
      && $stable(rot_z_o) && $stable(out_w_o))
    else $error("stalled result changed");

  // The input side stalls only when the output is full and held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output can drain");

  // A freely flowing transaction emerges after the pipeline depth with its w intact.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      |=> out_valid_o && out_w_o == $past(vec_w_i, 4))
    else $error("result missing or w corrupted");

  // Without any configuration write since reset the rotation is the identity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      |=> cfg_seen_q || (rot_x_o == $past(vec_x_i, 4) && rot_y_o == $past(vec_y_i, 4)
        && rot_z_o == $past(vec_z_i, 4)))
    else $error("reset rotation is not the identity");

  // A configuration write carries a known index and value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !$isunknown(cfg_idx_i) && !$isunknown(cfg_data_i))
    else $error("configuration write with unknown index or value");

endmodule

bind quaternion_vector_rotate qvr_checker #(
  .VEC_WIDTH (VEC_WIDTH),
  .QUAT_WIDTH(QUAT_WIDTH)
) u_qvr_checker (.*);

/* tb/tb_quaternion_vector_rotate.sv */
// Testbench for quaternion_vector_rotate: directed and random vector streams under
// several quaternion settings, checked against a predictor of the rotation datapath.
// Depends on qvr_pkg and the quaternion_vector_rotate RTL only.
`timescale 1ns / 1ps

module tb_quaternion_vector_rotate;

  localparam int VW = qvr_pkg::VEC_WIDTH_DEF;
  localparam int QW = qvr_pkg::QUAT_WIDTH_DEF;
  localparam int QF = QW - 1;
  localparam int PIPE_LATENCY = 5;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 150;
  localparam logic signed [VW-1:0] VEC_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VEC_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [QW-1:0] Q_HALF_SQRT2 = 16'sd23170;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
    logic signed [VW-1:0] w;
  } vec4_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [qvr_pkg::CFG_IDX_W-1:0] cfg_idx_i = qvr_pkg::REG_QUAT_X;
  logic [QW-1:0]                 cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic signed [VW-1:0]          vec_x_i = '0;
  logic signed [VW-1:0]          vec_y_i = '0;
  logic signed [VW-1:0]          vec_z_i = '0;
  logic signed [VW-1:0]          vec_w_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [VW-1:0]          rot_x_o;
  logic signed [VW-1:0]          rot_y_o;
  logic signed [VW-1:0]          rot_z_o;
  logic signed [VW-1:0]          out_w_o;

  logic signed [QW-1:0] quat_i_q = '0;
  logic signed [QW-1:0] quat_j_q = '0;
  logic signed [QW-1:0] quat_k_q = '0;
  logic signed [QW-1:0] quat_s_q = Q_MAX;

  vec4_t expected_rot[$];
  int    error_count = 0;
  int    vectors_sent = 0;
  int    results_checked = 0;
  int    quats_loaded = 0;
  bit    gaps_on = 1'b0;
  bit    stalls_on = 1'b0;
  int    stall_left = 0;
  int    stall_roll;

  quaternion_vector_rotate u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .vec_x_i    (vec_x_i),
    .vec_y_i    (vec_y_i),
    .vec_z_i    (vec_z_i),
    .vec_w_i    (vec_w_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .rot_x_o    (rot_x_o),
    .rot_y_o    (rot_y_o),
    .rot_z_o    (rot_z_o),
    .out_w_o    (out_w_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic longint matrix_term(input bit unit_base, input longint twice_sum);
    longint acc;
    acc = twice_sum + (unit_base ? (longint'(1) << (2 * QF)) : longint'(0));
    return (acc + (longint'(1) << (QF - 1))) >>> QF;
  endfunction

  function automatic logic signed [VW-1:0] saturate_row(input longint acc);
    longint r;
    r = (acc + (longint'(1) << (QF - 1))) >>> QF;
    if (r > longint'(VEC_MAX)) r = longint'(VEC_MAX);
    if (r < longint'(VEC_MIN)) r = longint'(VEC_MIN);
    return r[VW-1:0];
  endfunction

  function automatic vec4_t rotate_vector(input vec4_t v);
    longint qi, qj, qk, qu, vx, vy, vz;
    longint ii, jj, kk, ui, uj, uk, ij, ik, jk;
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
    vec4_t r;
    qi = longint'(quat_i_q);
    qj = longint'(quat_j_q);
    qk = longint'(quat_k_q);
    qu = longint'(quat_s_q);
    vx = longint'(v.x);
    vy = longint'(v.y);
    vz = longint'(v.z);
    ii = qi * qi;  jj = qj * qj;  kk = qk * qk;
    ui = qu * qi;  uj = qu * qj;  uk = qu * qk;
    ij = qi * qj;  ik = qi * qk;  jk = qj * qk;
    m00 = matrix_term(1'b1, -2 * (jj + kk));
    m01 = matrix_term(1'b0, 2 * (ij - uk));
    m02 = matrix_term(1'b0, 2 * (ik + uj));
    m10 = matrix_term(1'b0, 2 * (ij + uk));
    m11 = matrix_term(1'b1, -2 * (ii + kk));
    m12 = matrix_term(1'b0, 2 * (jk - ui));
    m20 = matrix_term(1'b0, 2 * (ik - uj));
    m21 = matrix_term(1'b0, 2 * (jk + ui));
    m22 = matrix_term(1'b1, -2 * (ii + jj));
    r.x = saturate_row(m00 * vx + m01 * vy + m02 * vz);
    r.y = saturate_row(m10 * vx + m11 * vy + m12 * vz);
    r.z = saturate_row(m20 * vx + m21 * vy + m22 * vz);
    r.w = v.w;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic signed [VW-1:0] pick_component();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return VW'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    if (r < 16) return VW'($urandom);
    case (r)
      16: return VEC_MAX;
      17: return VEC_MIN;
      18: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic vec4_t make_vec(input logic signed [VW-1:0] x, input logic signed [VW-1:0] y,
                                     input logic signed [VW-1:0] z, input logic signed [VW-1:0] w);
    vec4_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    v.w = w;
    return v;
  endfunction

  always @(posedge clk_i) begin
    if (!stalls_on) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 20) stall_left = $urandom_range(1, 3);
      else if (stall_roll < 23) stall_left = $urandom_range(8, 30);
    end
  end

  task automatic report_field(input string name, input logic signed [VW-1:0] want,
                              input logic signed [VW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_result
    vec4_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rot.size() == 0) begin
        $display("%0t: result with no transaction pending: x=%0d y=%0d z=%0d w=%0d",
                 $time, rot_x_o, rot_y_o, rot_z_o, out_w_o);
        error_count++;
      end else begin
        want = expected_rot.pop_front();
        report_field("rot_x", want.x, rot_x_o);
        report_field("rot_y", want.y, rot_y_o);
        report_field("rot_z", want.z, rot_z_o);
        report_field("out_w", want.w, out_w_o);
        results_checked++;
      end
    end
  end

  // Called at a rising edge; returns at the edge that accepted the transaction.
  task automatic send_vector(input vec4_t v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    vec_x_i <= v.x;
    vec_y_i <= v.y;
    vec_z_i <= v.z;
    vec_w_i <= v.w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_rot.push_back(rotate_vector(v));
    vectors_sent++;
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (expected_rot.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY) @(posedge clk_i);
  endtask

  // The block is idle here; the hold-off afterwards covers the matrix rebuild.
  task automatic load_quat(input logic signed [QW-1:0] qi, input logic signed [QW-1:0] qj,
                           input logic signed [QW-1:0] qk, input logic signed [QW-1:0] qs);
    wait_all_results();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= qvr_pkg::REG_QUAT_X;
    cfg_data_i <= qi;
    @(posedge clk_i);
    cfg_idx_i <= qvr_pkg::REG_QUAT_Y;
    cfg_data_i <= qj;
    @(posedge clk_i);
    cfg_idx_i <= qvr_pkg::REG_QUAT_Z;
    cfg_data_i <= qk;
    @(posedge clk_i);
    cfg_idx_i <= qvr_pkg::REG_QUAT_SCALAR;
    cfg_data_i <= qs;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    quat_i_q = qi;
    quat_j_q = qj;
    quat_k_q = qk;
    quat_s_q = qs;
    quats_loaded++;
    repeat (PIPE_LATENCY) @(posedge clk_i);
  endtask

  task automatic load_random_quat(input bit unit_norm);
    real a, b, c, d, n;
    if (!unit_norm) begin
      load_quat(QW'($urandom), QW'($urandom), QW'($urandom), QW'($urandom));
    end else begin
      a = real'($urandom_range(0, 2000)) - 1000.0;
      b = real'($urandom_range(0, 2000)) - 1000.0;
      c = real'($urandom_range(0, 2000)) - 1000.0;
      d = real'($urandom_range(0, 2000)) - 1000.0;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) begin
        a = 0.0;
        b = 0.0;
        c = 0.0;
        d = 1.0;
        n = 1.0;
      end
      load_quat(QW'($rtoi(a / n * 32767.0)), QW'($rtoi(b / n * 32767.0)),
                QW'($rtoi(c / n * 32767.0)), QW'($rtoi(d / n * 32767.0)));
    end
  endtask

  task automatic test_identity_at_reset();
    send_vector(make_vec(VEC_MAX, VEC_MAX, VEC_MAX, VEC_MAX));
    send_vector(make_vec(VEC_MIN, VEC_MIN, VEC_MIN, VEC_MIN));
    send_vector(make_vec('0, '0, '0, '0));
    send_vector(make_vec('1, 24'sd1, '1, 24'sd1));
    send_vector(make_vec(24'sd4096, -24'sd8192, 24'sd12288, VEC_MIN));
  endtask

  task automatic test_axis_rotations();
    load_quat('0, '0, Q_HALF_SQRT2, Q_HALF_SQRT2);
    send_vector(make_vec(24'sd4096, '0, '0, 24'sd7));
    send_vector(make_vec('0, 24'sd4096, '0, '1));
    send_vector(make_vec(VEC_MAX, VEC_MIN, '0, VEC_MAX));
    load_quat(Q_HALF_SQRT2, '0, '0, Q_HALF_SQRT2);
    send_vector(make_vec('0, 24'sd4096, 24'sd4096, '0));
    send_vector(make_vec(VEC_MIN, VEC_MAX, VEC_MIN, VEC_MIN));
    load_quat('0, Q_HALF_SQRT2, '0, Q_HALF_SQRT2);
    send_vector(make_vec(24'sd4096, 24'sd2048, -24'sd4096, 24'sd1));
    send_vector(make_vec(VEC_MAX, VEC_MAX, VEC_MAX, '0));
    // A half turn about x with the i component at its most negative value.
    load_quat(Q_MIN, '0, '0, '0);
    send_vector(make_vec(24'sd4096, 24'sd4096, -24'sd4096, 24'sd3));
    send_vector(make_vec(VEC_MAX, VEC_MIN, VEC_MAX, VEC_MAX));
  endtask

  task automatic test_extreme_quats();
    load_quat(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_vector(make_vec(VEC_MAX, VEC_MAX, VEC_MAX, VEC_MAX));
    send_vector(make_vec(VEC_MIN, 24'sd1, VEC_MAX, VEC_MIN));
    send_vector(make_vec(24'sd4096, '0, '0, '0));
    load_quat(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_vector(make_vec(VEC_MIN, VEC_MIN, VEC_MIN, '1));
    send_vector(make_vec(24'sd100, -24'sd100, 24'sd100, 24'sd5));
    load_quat('0, '0, '0, '0);
    send_vector(make_vec(VEC_MAX, VEC_MIN, 24'sd4096, VEC_MAX));
  endtask

  task automatic test_random_streams();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      load_random_quat(phase % 3 != 0);
      gaps_on = (phase != 0) && (phase != 2);
      stalls_on = (phase != 0) && (phase != 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 5 && n == PHASE_ITEMS / 2) wait_all_results();
        send_vector(make_vec(pick_component(), pick_component(), pick_component(),
                             VW'($urandom)));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_identity_at_reset();
    test_axis_rotations();
    test_extreme_quats();
    test_random_streams();
    wait_all_results();
    $display("Rotated %0d vectors under %0d quaternion settings plus the reset identity.",
             vectors_sent, quats_loaded);
    $display("Compared %0d results, including saturated and non-unit cases.",
             results_checked);
    if (error_count == 0 && expected_rot.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
